[src/wie_pkg.sv]
// ----------------------------------------------------------------------------
// wie_pkg: shared types and constants of the i32 stack executor
// Opcode and status codes, the instruction decode, the controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package wie_pkg;

    localparam int DEPTH_W = 11;

    localparam logic [7:0] OP_UNREACHABLE = 8'h00;
    localparam logic [7:0] OP_NOP         = 8'h01;
    localparam logic [7:0] OP_BLOCK       = 8'h02;
    localparam logic [7:0] OP_LOOP        = 8'h03;
    localparam logic [7:0] OP_IF          = 8'h04;
    localparam logic [7:0] OP_ELSE        = 8'h05;
    localparam logic [7:0] OP_END         = 8'h0B;
    localparam logic [7:0] OP_BR          = 8'h0C;
    localparam logic [7:0] OP_BR_IF       = 8'h0D;
    localparam logic [7:0] OP_RETURN      = 8'h0F;
    localparam logic [7:0] OP_DROP        = 8'h1A;
    localparam logic [7:0] OP_SELECT      = 8'h1B;
    localparam logic [7:0] OP_LOCAL_GET   = 8'h20;
    localparam logic [7:0] OP_LOCAL_SET   = 8'h21;
    localparam logic [7:0] OP_LOCAL_TEE   = 8'h22;
    localparam logic [7:0] OP_LOAD        = 8'h28;
    localparam logic [7:0] OP_STORE       = 8'h36;
    localparam logic [7:0] OP_CONST       = 8'h41;
    localparam logic [7:0] OP_EQZ         = 8'h45;
    localparam logic [7:0] OP_EQ          = 8'h46;
    localparam logic [7:0] OP_NE          = 8'h47;
    localparam logic [7:0] OP_LT_S        = 8'h48;
    localparam logic [7:0] OP_GT_S        = 8'h4A;
    localparam logic [7:0] OP_LE_S        = 8'h4C;
    localparam logic [7:0] OP_GE_S        = 8'h4E;
    localparam logic [7:0] OP_ADD         = 8'h6A;
    localparam logic [7:0] OP_SUB         = 8'h6B;
    localparam logic [7:0] OP_MUL         = 8'h6C;
    localparam logic [7:0] OP_DIV_S       = 8'h6D;
    localparam logic [7:0] OP_AND         = 8'h71;
    localparam logic [7:0] OP_OR          = 8'h72;
    localparam logic [7:0] OP_XOR         = 8'h73;
    localparam logic [7:0] OP_SHL         = 8'h74;
    localparam logic [7:0] OP_SHR_S       = 8'h75;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_HALTED      = 4'd1;
    localparam logic [3:0] ST_UNREACHABLE = 4'd2;
    localparam logic [3:0] ST_UNKNOWN     = 4'd3;
    localparam logic [3:0] ST_BAD_LOCAL   = 4'd4;
    localparam logic [3:0] ST_OOB         = 4'd5;
    localparam logic [3:0] ST_UNDERFLOW   = 4'd6;
    localparam logic [3:0] ST_OVERFLOW    = 4'd7;
    localparam logic [3:0] ST_DIV_ZERO    = 4'd8;
    localparam logic [3:0] ST_DIV_OVF     = 4'd9;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_RD_B,
        S_RD_C,
        S_ADDR,
        S_ACCESS,
        S_EXEC,
        S_DIV,
        S_COMMIT,
        S_REFILL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       known;
        logic [1:0] pops;
        logic       push;
        logic       is_mem;
        logic       is_load;
        logic       is_local;
        logic       is_div;
    } t_decode;

    typedef struct packed {
        logic clear;
        logic take_in;
        logic check;
        logic cap_b;
        logic cap_c;
        logic calc_addr;
        logic access;
        logic exec;
        logic div_start;
        logic div_cap;
        logic commit;
        logic refill;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic trap;
        logic need_b;
        logic need_c;
        logic is_mem;
        logic is_load;
        logic is_div;
        logic oob;
        logic div_fault;
        logic div_done;
        logic refill;
        logic out_free;
    } t_stat;

    function automatic t_decode decode(input logic [7:0] op);
        t_decode d;
        d = '0;
        d.known = 1'b1;
        unique case (op)
            OP_UNREACHABLE, OP_RETURN, OP_NOP, OP_BLOCK, OP_LOOP, OP_ELSE,
            OP_END, OP_BR: begin
            end
            OP_IF, OP_BR_IF, OP_DROP: begin
                d.pops = 2'd1;
            end
            OP_LOCAL_SET: begin
                d.pops     = 2'd1;
                d.is_local = 1'b1;
            end
            OP_LOCAL_TEE: begin
                d.pops     = 2'd1;
                d.push     = 1'b1;
                d.is_local = 1'b1;
            end
            OP_LOCAL_GET: begin
                d.push     = 1'b1;
                d.is_local = 1'b1;
            end
            OP_SELECT: begin
                d.pops = 2'd3;
                d.push = 1'b1;
            end
            OP_CONST: begin
                d.push = 1'b1;
            end
            OP_EQZ: begin
                d.pops = 2'd1;
                d.push = 1'b1;
            end
            OP_LOAD: begin
                d.pops    = 2'd1;
                d.push    = 1'b1;
                d.is_mem  = 1'b1;
                d.is_load = 1'b1;
            end
            OP_STORE: begin
                d.pops   = 2'd2;
                d.is_mem = 1'b1;
            end
            OP_DIV_S: begin
                d.pops   = 2'd2;
                d.push   = 1'b1;
                d.is_div = 1'b1;
            end
            OP_EQ, OP_NE, OP_LT_S, OP_GT_S, OP_LE_S, OP_GE_S, OP_ADD, OP_SUB,
            OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR_S: begin
                d.pops = 2'd2;
                d.push = 1'b1;
            end
            default: begin
                d.known = 1'b0;
            end
        endcase
        return d;
    endfunction

endpackage

[src/wie_in_if.sv]
// ----------------------------------------------------------------------------
// wie_in_if: instruction channel
// Valid/ready channel that carries one decoded instruction per beat.
// ----------------------------------------------------------------------------
interface wie_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         action;
    logic signed [31:0] immediate;
    logic signed [31:0] mem_offset;

    modport source (output valid, action, immediate, mem_offset, input ready);
    modport sink   (input valid, action, immediate, mem_offset, output ready);
endinterface

[src/wie_out_if.sv]
// ----------------------------------------------------------------------------
// wie_out_if: result channel
// Valid/ready channel that carries one execution result per beat.
// ----------------------------------------------------------------------------
interface wie_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         status;
    logic signed [31:0] top_value;
    logic [10:0]        stack_depth;
    logic               condition;

    modport source (output valid, status, top_value, stack_depth, condition,
                    input ready);
    modport sink   (input valid, status, top_value, stack_depth, condition,
                    output ready);
endinterface

[src/wie_div.sv]
// ----------------------------------------------------------------------------
// wie_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, with the sign
// applied to the truncated quotient at the output.
// ----------------------------------------------------------------------------
module wie_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [33:0] diff;

    assign diff = {1'b0, r_rem, r_quo[31]} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_dividend[31] ? -i_dividend : i_dividend;
            r_dvs <= i_divisor[31] ? -i_divisor : i_divisor;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            // A set top bit of the difference means the divisor did not fit.
            if (diff[33]) begin
                r_rem <= {r_rem[30:0], r_quo[31]};
            end else begin
                r_rem <= diff[31:0];
            end
            r_quo <= {r_quo[30:0], ~diff[33]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -r_quo : r_quo;
endmodule

[src/wie_datapath.sv]
// ----------------------------------------------------------------------------
// wie_datapath: stack executor datapath
// Value stack memory, locals store, four byte banks of data memory, operand
// and result registers, trap detection and the registered result stage.
// ----------------------------------------------------------------------------
module wie_datapath #(
    parameter int STACK_DEPTH  = 1024,
    parameter int LOCAL_COUNT  = 32,
    parameter int MEMORY_BYTES = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wie_pkg::t_cmd                i_cmd,
    output wie_pkg::t_stat               o_stat,
    input  logic [7:0]                   i_action,
    input  logic [31:0]                  i_immediate,
    input  logic [31:0]                  i_mem_offset,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [3:0]                   o_status,
    output logic [31:0]                  o_top_value,
    output logic [wie_pkg::DEPTH_W-1:0]  o_stack_depth,
    output logic                         o_condition
);
    localparam int SIW       = $clog2(STACK_DEPTH);
    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    localparam int STK_ROWS  = 1 << SIW;
    localparam int LIW       = $clog2(LOCAL_COUNT);
    localparam int LOC_ROWS  = 1 << LIW;
    localparam int BANK_ROWS = (MEMORY_BYTES + 3) / 4;
    localparam int RW        = $clog2(BANK_ROWS);
    localparam int AW        = RW + 2;
    localparam logic signed [33:0] EA_LAST = 34'(MEMORY_BYTES - 4);

    wie_pkg::t_decode r_dec;
    logic [7:0]       r_op;
    logic [31:0]      r_imm;
    logic [31:0]      r_off;
    logic [SPW-1:0]   r_sp;
    logic [31:0]      r_top;
    logic [31:0]      r_b;
    logic [31:0]      r_c;
    logic [31:0]      r_res;
    logic             r_cond;
    logic [3:0]       r_status;
    logic [3:0]       r_stop;
    logic [AW-1:0]    r_ea;
    logic             r_oob;
    logic [RW-1:0]    r_clr_row;

    logic [31:0]         r_loc [LOC_ROWS];
    logic [LOC_ROWS-1:0] r_lvalid;
    logic [31:0]         r_loc_q;
    logic                r_loc_v;

    logic [31:0]      r_stack [STK_ROWS];
    logic [31:0]      r_stk_q;

    logic                       r_out_valid;
    logic [3:0]                 r_out_status;
    logic [31:0]                r_out_top;
    logic [wie_pkg::DEPTH_W-1:0] r_out_depth;
    logic                       r_out_cond;

    logic [SPW:0]     sp_ext;
    logic [SPW:0]     sp_after;
    logic [SPW-1:0]   new_sp;
    logic [3:0]       early_status;
    logic [31:0]      addr_opnd;
    logic signed [33:0] ea_sum;
    logic             ea_oob;
    logic [31:0]      load_word;
    logic [31:0]      prod_lo;
    logic [31:0]      exec_res;
    logic             div_zero;
    logic             div_ovf;
    logic             div_done;
    logic [31:0]      div_q;
    logic [SIW-1:0]   stk_raddr;
    logic [SIW-1:0]   stk_waddr;
    logic             stk_we;
    logic [LIW-1:0]   loc_idx;
    logic             loc_we;
    logic             bank_re;
    logic             bank_st;
    logic             out_free;
    logic [7:0]       bank_q [4];

    assign sp_ext   = {1'b0, r_sp};
    assign sp_after = sp_ext - (SPW+1)'(r_dec.pops) + (SPW+1)'(r_dec.push);
    assign new_sp   = sp_after[SPW-1:0];
    assign loc_idx  = r_imm[LIW-1:0];
    assign out_free = !r_out_valid || i_ready;

    // Trap priority: a stopped block repeats its code, then decode traps,
    // then underflow, bad local and overflow.
    always_comb begin
        priority if (r_stop != wie_pkg::ST_OK) begin
            early_status = r_stop;
        end else if (!r_dec.known) begin
            early_status = wie_pkg::ST_UNKNOWN;
        end else if (r_op == wie_pkg::OP_UNREACHABLE) begin
            early_status = wie_pkg::ST_UNREACHABLE;
        end else if (r_op == wie_pkg::OP_RETURN) begin
            early_status = wie_pkg::ST_HALTED;
        end else if (sp_ext < (SPW+1)'(r_dec.pops)) begin
            early_status = wie_pkg::ST_UNDERFLOW;
        end else if (r_dec.is_local && r_imm >= 32'(LOCAL_COUNT)) begin
            early_status = wie_pkg::ST_BAD_LOCAL;
        end else if (sp_after > (SPW+1)'(STACK_DEPTH)) begin
            early_status = wie_pkg::ST_OVERFLOW;
        end else begin
            early_status = wie_pkg::ST_OK;
        end
    end

    // Load takes its address from the top, store from the value below it.
    assign addr_opnd = r_dec.is_load ? r_top : r_b;
    assign ea_sum    = {{2{addr_opnd[31]}}, addr_opnd} + {{2{r_off[31]}}, r_off};
    assign ea_oob    = (ea_sum < 34'sd0) || (ea_sum > EA_LAST);

    assign prod_lo  = r_b * r_top;
    assign div_zero = (r_top == 32'd0);
    assign div_ovf  = (r_b == 32'h8000_0000) && (r_top == 32'hFFFF_FFFF);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            load_word[8*k +: 8] = bank_q[2'(r_ea[1:0] + 2'(k))];
        end
    end

    always_comb begin
        unique case (r_op)
            wie_pkg::OP_LOCAL_GET: exec_res = r_loc_v ? r_loc_q : 32'd0;
            wie_pkg::OP_LOCAL_TEE: exec_res = r_top;
            wie_pkg::OP_LOAD:      exec_res = load_word;
            wie_pkg::OP_CONST:     exec_res = r_imm;
            wie_pkg::OP_EQZ:       exec_res = 32'(r_top == 32'd0);
            wie_pkg::OP_SELECT:    exec_res = (r_top != 32'd0) ? r_c : r_b;
            wie_pkg::OP_EQ:        exec_res = 32'(r_b == r_top);
            wie_pkg::OP_NE:        exec_res = 32'(r_b != r_top);
            wie_pkg::OP_LT_S:      exec_res = 32'($signed(r_b) < $signed(r_top));
            wie_pkg::OP_GT_S:      exec_res = 32'($signed(r_b) > $signed(r_top));
            wie_pkg::OP_LE_S:      exec_res = 32'($signed(r_b) <= $signed(r_top));
            wie_pkg::OP_GE_S:      exec_res = 32'($signed(r_b) >= $signed(r_top));
            wie_pkg::OP_ADD:       exec_res = r_b + r_top;
            wie_pkg::OP_SUB:       exec_res = r_b - r_top;
            wie_pkg::OP_MUL:       exec_res = prod_lo;
            wie_pkg::OP_AND:       exec_res = r_b & r_top;
            wie_pkg::OP_OR:        exec_res = r_b | r_top;
            wie_pkg::OP_XOR:       exec_res = r_b ^ r_top;
            wie_pkg::OP_SHL:       exec_res = r_b << r_top[4:0];
            wie_pkg::OP_SHR_S:     exec_res = 32'($signed(r_b) >>> r_top[4:0]);
            default:               exec_res = 32'd0;
        endcase
    end

    wie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_b),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Value stack: one read and one write port, read data registered.
    always_comb begin
        priority if (i_cmd.cap_b) begin
            stk_raddr = SIW'(r_sp - SPW'(3));
        end else if (i_cmd.commit) begin
            stk_raddr = SIW'(new_sp - SPW'(1));
        end else begin
            stk_raddr = SIW'(r_sp - SPW'(2));
        end
    end
    assign stk_waddr = SIW'(r_sp - SPW'(r_dec.pops));
    assign stk_we    = i_cmd.commit && r_dec.push;

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= r_res;
        end
        r_stk_q <= r_stack[stk_raddr];
    end

    // Locals store; an entry never written reads as zero.
    assign loc_we = i_cmd.commit && r_dec.is_local && (r_op != wie_pkg::OP_LOCAL_GET);

    always_ff @(posedge i_clk) begin
        if (loc_we) begin
            r_loc[loc_idx] <= r_top;
        end
        if (i_cmd.check) begin
            r_loc_q <= r_loc[loc_idx];
            r_loc_v <= r_lvalid[loc_idx];
        end
    end

    // Data memory: byte lane j holds every address with low bits equal to j.
    assign bank_re = i_cmd.access && r_dec.is_load;
    assign bank_st = i_cmd.access && !r_oob && r_dec.is_mem && !r_dec.is_load;

    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic [7:0]    r_mem [BANK_ROWS];
        logic [7:0]    r_q;
        logic [1:0]    lane;
        logic [RW-1:0] row;
        logic [RW-1:0] waddr;
        logic [7:0]    wdata;

        assign lane  = 2'(j) - r_ea[1:0];
        assign row   = r_ea[AW-1:2] + RW'(2'(j) < r_ea[1:0]);
        assign waddr = i_cmd.clear ? r_clr_row : row;
        assign wdata = i_cmd.clear ? 8'h00 : 8'(r_top >> {lane, 3'b000});

        always_ff @(posedge i_clk) begin
            if (i_cmd.clear || bank_st) begin
                r_mem[waddr] <= wdata;
            end
            if (bank_re) begin
                r_q <= r_mem[row];
            end
        end

        assign bank_q[j] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_stop      <= wie_pkg::ST_OK;
            r_lvalid    <= '0;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_row <= r_clr_row + RW'(1);
            end
            if (i_cmd.commit) begin
                r_sp <= new_sp;
            end
            if (loc_we) begin
                r_lvalid[loc_idx] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_stop      <= r_status;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_op   <= i_action;
            r_dec  <= wie_pkg::decode(i_action);
            r_imm  <= i_immediate;
            r_off  <= i_mem_offset;
            r_cond <= 1'b0;
        end
        if (i_cmd.check) begin
            r_status <= early_status;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_stk_q;
        end
        if (i_cmd.cap_c) begin
            r_c <= r_stk_q;
        end
        if (i_cmd.calc_addr) begin
            r_ea  <= ea_sum[AW-1:0];
            r_oob <= ea_oob;
        end
        if (i_cmd.access && r_oob) begin
            r_status <= wie_pkg::ST_OOB;
        end
        if (i_cmd.exec) begin
            r_res  <= exec_res;
            r_cond <= ((r_op == wie_pkg::OP_IF) || (r_op == wie_pkg::OP_BR_IF)) &&
                      (r_top != 32'd0);
            if (r_dec.is_div && div_zero) begin
                r_status <= wie_pkg::ST_DIV_ZERO;
            end else if (r_dec.is_div && div_ovf) begin
                r_status <= wie_pkg::ST_DIV_OVF;
            end
        end
        if (i_cmd.div_cap) begin
            r_res <= div_q;
        end
        if (i_cmd.commit && r_dec.push) begin
            r_top <= r_res;
        end
        if (i_cmd.refill) begin
            r_top <= r_stk_q;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_top    <= (r_sp != '0) ? r_top : 32'd0;
            r_out_depth  <= wie_pkg::DEPTH_W'(r_sp);
            r_out_cond   <= r_cond;
        end
    end

    assign o_stat.clear_last = (r_clr_row == RW'(BANK_ROWS - 1));
    assign o_stat.trap       = (early_status != wie_pkg::ST_OK);
    assign o_stat.need_b     = (r_dec.pops >= 2'd2);
    assign o_stat.need_c     = (r_dec.pops == 2'd3);
    assign o_stat.is_mem     = r_dec.is_mem;
    assign o_stat.is_load    = r_dec.is_load;
    assign o_stat.is_div     = r_dec.is_div;
    assign o_stat.oob        = r_oob;
    assign o_stat.div_fault  = r_dec.is_div && (div_zero || div_ovf);
    assign o_stat.div_done   = div_done;
    assign o_stat.refill     = !r_dec.push && (r_dec.pops != 2'd0) && (new_sp != '0);
    assign o_stat.out_free   = out_free;

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_top_value   = r_out_top;
    assign o_stack_depth = r_out_depth;
    assign o_condition   = r_out_cond;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_stop_holds_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop != wie_pkg::ST_OK) |=> $stable(r_sp))
        else $error("stack changed after the block stopped");

    a_stop_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_stop != wie_pkg::ST_OK) |-> (r_status == r_stop))
        else $error("stopped block reported a different code");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_dec.push) |-> (sp_after <= (SPW+1)'(STACK_DEPTH)))
        else $error("push committed past stack depth");
endmodule

[src/wie_ctrl.sv]
// ----------------------------------------------------------------------------
// wie_ctrl: stack executor controller
// Sequences the memory clearing pass and each instruction through operand
// reads, address check, execution, commit and result hand-off.
// ----------------------------------------------------------------------------
module wie_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wie_pkg::t_stat i_stat,
    output wie_pkg::t_cmd  o_cmd
);
    wie_pkg::t_state r_state;
    wie_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wie_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            wie_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = wie_pkg::S_IDLE;
                end
            end
            wie_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = wie_pkg::S_CHECK;
                end
            end
            wie_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                priority if (i_stat.trap) begin
                    n_state = wie_pkg::S_DONE;
                end else if (i_stat.need_b) begin
                    n_state = wie_pkg::S_RD_B;
                end else if (i_stat.is_mem) begin
                    n_state = wie_pkg::S_ADDR;
                end else begin
                    n_state = wie_pkg::S_EXEC;
                end
            end
            wie_pkg::S_RD_B: begin
                o_cmd.cap_b = 1'b1;
                priority if (i_stat.need_c) begin
                    n_state = wie_pkg::S_RD_C;
                end else if (i_stat.is_mem) begin
                    n_state = wie_pkg::S_ADDR;
                end else begin
                    n_state = wie_pkg::S_EXEC;
                end
            end
            wie_pkg::S_RD_C: begin
                o_cmd.cap_c = 1'b1;
                n_state     = wie_pkg::S_EXEC;
            end
            wie_pkg::S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = wie_pkg::S_ACCESS;
            end
            wie_pkg::S_ACCESS: begin
                o_cmd.access = 1'b1;
                priority if (i_stat.oob) begin
                    n_state = wie_pkg::S_DONE;
                end else if (i_stat.is_load) begin
                    n_state = wie_pkg::S_EXEC;
                end else begin
                    n_state = wie_pkg::S_COMMIT;
                end
            end
            wie_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_stat.div_fault) begin
                    n_state = wie_pkg::S_DONE;
                end else if (i_stat.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = wie_pkg::S_DIV;
                end else begin
                    n_state = wie_pkg::S_COMMIT;
                end
            end
            wie_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = wie_pkg::S_COMMIT;
                end
            end
            wie_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                // A pop that leaves values behind must fetch the new top.
                if (i_stat.refill) begin
                    n_state = wie_pkg::S_REFILL;
                end else begin
                    n_state = wie_pkg::S_DONE;
                end
            end
            wie_pkg::S_REFILL: begin
                o_cmd.refill = 1'b1;
                n_state      = wie_pkg::S_DONE;
            end
            wie_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = wie_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wie_pkg::S_IDLE;
            end
        endcase
    end
endmodule

[src/wasm_i32_stack_executor.sv]
// ----------------------------------------------------------------------------
// Each accepted beat goes through the check, then the operand reads, address
// and memory access, execution or divide, commit and refill as it needs them,
// then the result register; a step that stops at the check goes there directly.
// Throughput: one instruction at a time; the next beat is accepted only after
// the result is registered, and a result held at the output delays it.
// Reset: stack empty, block running, locals read as zero; a clearing pass
// zeroes data memory before the first beat is taken.
// ----------------------------------------------------------------------------
// wasm_i32_stack_executor: WebAssembly i32 stack machine
// Executes one decoded i32 instruction per beat against a value stack, a
// locals store and a little-endian byte memory, with sticky traps.
// ----------------------------------------------------------------------------
module wasm_i32_stack_executor #(
    parameter int STACK_DEPTH  = 1024,
    parameter int LOCAL_COUNT  = 32,
    parameter int MEMORY_BYTES = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wie_in_if.sink    i_cmd,
    wie_out_if.source o_res
);
    wie_pkg::t_cmd  cmd;
    wie_pkg::t_stat stat;
    logic           in_ready;

    wie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wie_datapath #(
        .STACK_DEPTH  (STACK_DEPTH),
        .LOCAL_COUNT  (LOCAL_COUNT),
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_cmd.action),
        .i_immediate   (i_cmd.immediate),
        .i_mem_offset  (i_cmd.mem_offset),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_status      (o_res.status),
        .o_top_value   (o_res.top_value),
        .o_stack_depth (o_res.stack_depth),
        .o_condition   (o_res.condition)
    );

    assign i_cmd.ready = in_ready;
endmodule
